// ===== rtl/lsag_pkg.sv =====
`timescale 1ns / 1ps

package lsag_pkg;

    // operation kinds
    localparam logic [3:0] KIND_LDR   = 4'd0;
    localparam logic [3:0] KIND_LDRB  = 4'd1;
    localparam logic [3:0] KIND_LDRT  = 4'd2;
    localparam logic [3:0] KIND_LDRBT = 4'd3;
    localparam logic [3:0] KIND_STR   = 4'd4;
    localparam logic [3:0] KIND_STRB  = 4'd5;
    localparam logic [3:0] KIND_STRT  = 4'd6;
    localparam logic [3:0] KIND_STRBT = 4'd7;
    localparam logic [3:0] KIND_LDRD  = 4'd8;
    localparam logic [3:0] KIND_LDRH  = 4'd9;
    localparam logic [3:0] KIND_LDRSB = 4'd10;
    localparam logic [3:0] KIND_LDRSH = 4'd11;
    localparam logic [3:0] KIND_STRD  = 4'd12;
    localparam logic [3:0] KIND_STRH  = 4'd13;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;

    // shift types
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // mode 3 sh field
    localparam logic [1:0] SH_NONE  = 2'd0;
    localparam logic [1:0] SH_HALF  = 2'd1;
    localparam logic [1:0] SH_SBYTE = 2'd2;
    localparam logic [1:0] SH_SHALF = 2'd3;

    localparam logic [3:0] REG_LR = 4'd14;

    // decoded instruction, decode to address stage
    typedef struct packed {
        logic        exec;
        logic        bad_enc;
        logic        translated;
        logic        pair;
        logic        half;
        logic        pre;
        logic        up;
        logic        wback;
        logic [3:0]  kind;
        logic [3:0]  rd;
        logic [31:0] offset;
    } dec_t;

    // one result transaction
    typedef struct packed {
        logic        executes;
        logic        undefined;
        logic [3:0]  op_kind;
        logic        access_enable;
        logic [31:0] address;
        logic [3:0]  target_register;
        logic        user_bank;
        logic        writeback_enable;
        logic [31:0] writeback_value;
    } res_t;

endpackage

// ===== rtl/lsag_shift.sv =====
`timescale 1ns / 1ps

module lsag_shift
    import lsag_pkg::*;
(
    input  logic [31:0] value,
    input  logic [4:0]  amount,
    input  logic [1:0]  shift_type,
    input  logic        carry,
    output logic [31:0] result
);

    logic [63:0] rot_wide;

    // rotate through a doubled word
    assign rot_wide = {value, value} >> amount;

    // barrel shifter with the immediate-zero special forms
    always_comb
    begin
        unique case (shift_type)
            SHIFT_LSL: result = value << amount;
            SHIFT_LSR: result = (amount == 5'd0) ? 32'd0 : (value >> amount);
            SHIFT_ASR: result = (amount == 5'd0) ? {32{value[31]}}
                                                 : 32'($signed(value) >>> amount);
            SHIFT_ROR: result = (amount == 5'd0) ? {carry, value[31:1]} : rot_wide[31:0];
            default:   result = value;
        endcase
    end

endmodule

// ===== rtl/lsag_decode.sv =====
`timescale 1ns / 1ps

module lsag_decode
    import lsag_pkg::*;
(
    input  logic [31:0] instruction,
    input  logic [31:0] index_value,
    input  logic [3:0]  status_flags,
    output dec_t        dec
);

    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        cond_pass;
    logic [31:0] shifted;
    logic        is_mode2;
    logic        is_mode3;
    logic        translated;
    logic [1:0]  sh;
    logic [3:0]  kind3;

    assign flag_n = status_flags[3];
    assign flag_z = status_flags[2];
    assign flag_c = status_flags[1];
    assign flag_v = status_flags[0];

    // condition evaluation, always and never-field both pass
    always_comb
    begin
        unique case (instruction[31:28])
            COND_EQ: cond_pass = flag_z;
            COND_NE: cond_pass = !flag_z;
            COND_CS: cond_pass = flag_c;
            COND_CC: cond_pass = !flag_c;
            COND_MI: cond_pass = flag_n;
            COND_PL: cond_pass = !flag_n;
            COND_VS: cond_pass = flag_v;
            COND_VC: cond_pass = !flag_v;
            COND_HI: cond_pass = flag_c && !flag_z;
            COND_LS: cond_pass = !flag_c || flag_z;
            COND_GE: cond_pass = (flag_n == flag_v);
            COND_LT: cond_pass = (flag_n != flag_v);
            COND_GT: cond_pass = !flag_z && (flag_n == flag_v);
            COND_LE: cond_pass = flag_z || (flag_n != flag_v);
            default: cond_pass = 1'b1;
        endcase
    end

    // scaled register offset for mode 2
    lsag_shift u_shift (
        .value      (index_value),
        .amount     (instruction[11:7]),
        .shift_type (instruction[6:5]),
        .carry      (flag_c),
        .result     (shifted)
    );

    assign is_mode2   = (instruction[27:26] == 2'b01);
    assign is_mode3   = (instruction[27:25] == 3'b000) && instruction[7] && instruction[4];
    assign translated = !instruction[24] && instruction[21];
    assign sh         = instruction[6:5];

    // mode 3 operation kind
    always_comb
    begin
        kind3 = KIND_LDRD;
        if (instruction[20])
        begin
            unique case (sh)
                SH_HALF:  kind3 = KIND_LDRH;
                SH_SBYTE: kind3 = KIND_LDRSB;
                SH_SHALF: kind3 = KIND_LDRSH;
                default:  kind3 = KIND_LDR;
            endcase
        end
        else
        begin
            unique case (sh)
                SH_HALF:  kind3 = KIND_STRH;
                SH_SBYTE: kind3 = KIND_LDRD;
                SH_SHALF: kind3 = KIND_STRD;
                default:  kind3 = KIND_LDR;
            endcase
        end
    end

    // field decode and offset selection
    always_comb
    begin
        dec            = '0;
        dec.exec       = cond_pass;
        dec.pre        = instruction[24];
        dec.up         = instruction[23];
        dec.wback      = instruction[21];
        dec.rd         = instruction[15:12];
        if (is_mode2)
        begin
            dec.translated = translated;
            dec.kind       = {1'b0, !instruction[20], translated, instruction[22]};
            if (!instruction[25])
                dec.offset = {20'd0, instruction[11:0]};
            else
            begin
                dec.bad_enc = instruction[4];
                dec.offset  = shifted;
            end
        end
        else if (is_mode3)
        begin
            dec.bad_enc = (sh == SH_NONE);
            dec.kind    = (sh == SH_NONE) ? KIND_LDR : kind3;
            dec.pair    = (sh != SH_NONE) && (kind3 == KIND_LDRD || kind3 == KIND_STRD);
            dec.half    = (sh != SH_NONE) &&
                          (kind3 == KIND_LDRH || kind3 == KIND_LDRSH || kind3 == KIND_STRH);
            dec.offset  = instruction[22] ? {24'd0, instruction[11:8], instruction[3:0]}
                                          : index_value;
        end
        else
        begin
            dec.bad_enc = 1'b1;
        end
    end

endmodule

// ===== rtl/lsag_addr.sv =====
`timescale 1ns / 1ps

module lsag_addr
    import lsag_pkg::*;
(
    input  dec_t        dec,
    input  logic [31:0] base_value,
    output res_t        res
);

    logic [31:0] moved;
    logic [31:0] addr;
    logic        undef;

    // base plus or minus offset, pre-indexed forms use it as address
    assign moved = dec.up ? (base_value + dec.offset) : (base_value - dec.offset);
    assign addr  = dec.pre ? moved : base_value;

    // bad pair register or odd halfword address
    assign undef = dec.exec &&
                   ((dec.pair && (dec.rd[0] || dec.rd == REG_LR)) ||
                    (dec.half && addr[0]));

    // result assembly, bad encodings clear every decoded field except executes
    always_comb
    begin
        res          = '0;
        res.executes = dec.exec;
        if (dec.bad_enc)
            res.undefined = 1'b1;
        else
        begin
            res.undefined        = undef;
            res.op_kind          = dec.kind;
            res.access_enable    = dec.exec && !undef && !(dec.pair && (addr[2:0] != 3'd0));
            res.address          = addr;
            res.target_register  = dec.rd;
            res.user_bank        = dec.translated;
            res.writeback_enable = dec.exec && !undef && (!dec.pre || dec.wback);
            res.writeback_value  = moved;
        end
    end

endmodule

// ===== rtl/load_store_address_generator_top.sv =====
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+----------------------------------------------
// command   | start (busy idle 0) | instruction, base_value, index_value,
//           |                     | status_flags
// result    | done (one cycle)    | executes, undefined, op_kind, access_enable,
//           |                     | address, target_register, user_bank,
//           |                     | writeback_enable, writeback_value
//
// one transaction per cycle; the result passes the input register, then the result register
// path: input register, decode and shift, one 32-bit add, result register
// busy is held low, so a start is taken in every cycle
// rst_n clears only the valid flags; payload registers are not reset
// the receiver cannot stall: each done pulse lasts exactly one cycle

module load_store_address_generator_top
    import lsag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instruction,
    input  logic [31:0] base_value,
    input  logic [31:0] index_value,
    input  logic [3:0]  status_flags,
    output logic        done,
    output logic        executes,
    output logic        undefined,
    output logic [3:0]  op_kind,
    output logic        access_enable,
    output logic [31:0] address,
    output logic [3:0]  target_register,
    output logic        user_bank,
    output logic        writeback_enable,
    output logic [31:0] writeback_value
);

    logic        in_valid_reg;
    logic [31:0] ins_reg;
    logic [31:0] base_reg;
    logic [31:0] index_reg;
    logic [3:0]  flags_reg;
    logic        done_reg;
    res_t        res_next;
    res_t        res_reg;
    dec_t        dec;

    assign busy = 1'b0;

    // input register, valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ins_reg   <= instruction;
            base_reg  <= base_value;
            index_reg <= index_value;
            flags_reg <= status_flags;
        end
    end

    lsag_decode u_decode (
        .instruction  (ins_reg),
        .index_value  (index_reg),
        .status_flags (flags_reg),
        .dec          (dec)
    );

    lsag_addr u_addr (
        .dec        (dec),
        .base_value (base_reg),
        .res        (res_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            res_reg <= res_next;
    end

    assign done             = done_reg;
    assign executes         = res_reg.executes;
    assign undefined        = res_reg.undefined;
    assign op_kind          = res_reg.op_kind;
    assign access_enable    = res_reg.access_enable;
    assign address          = res_reg.address;
    assign target_register  = res_reg.target_register;
    assign user_bank        = res_reg.user_bank;
    assign writeback_enable = res_reg.writeback_enable;
    assign writeback_value  = res_reg.writeback_value;

    // checks
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a matching command");

    a_access_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done && access_enable |-> executes && !undefined)
        else $error("access enabled on failed or undefined transaction");

    a_wb_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done && writeback_enable |-> executes && !undefined)
        else $error("writeback enabled on failed or undefined transaction");

    a_pair_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done && access_enable && (op_kind == KIND_LDRD || op_kind == KIND_STRD)
            |-> address[2:0] == 3'd0)
        else $error("pair access to unaligned address");

    a_user_bank_mode2: assert property (@(posedge clk) disable iff (!rst_n)
        done && user_bank |-> op_kind[3] == 1'b0 && op_kind[1] == 1'b1)
        else $error("user bank flag on non-translated kind");

endmodule
